### hdl/ftu_pkg.sv
// Shared types and constants for the flowed-text unwrapper.
package ftu_pkg;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_DASH = 8'h2D;

    localparam int SIG_LEN = 4;
    localparam int SIG_W   = $clog2(SIG_LEN);
    // "-- \n", entry 0 first
    localparam logic [SIG_LEN-1:0][7:0] SIG_TEXT = {CH_NL, CH_SP, CH_DASH, CH_DASH};

    localparam int BURST_MAX = 4;
    localparam int BIDX_W    = $clog2(BURST_MAX);
    localparam int BCNT_W    = $clog2(BURST_MAX + 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [2:0] t_sig_cnt;

    typedef enum logic [6:0] {
        M_START  = 7'b0000001,
        M_QUOTED = 7'b0000010,
        M_PLAIN  = 7'b0000100,
        M_SP     = 7'b0001000,
        M_SPNL   = 7'b0010000,
        M_CHECK  = 7'b0100000,
        M_IGNORE = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [BIDX_W-1:0]         last_idx;
    } t_burst;

endpackage

### hdl/ftu_front.sv
// Front end: line state machine, turns each item into a burst of display bytes.
module ftu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_accept,
    input  logic [7:0]      i_in_byte,
    input  logic            i_start_of_text,
    output logic            o_valid,
    output ftu_pkg::t_burst o_burst
);

    ftu_pkg::t_mode    r_mode, n_mode, m;
    ftu_pkg::t_sig_cnt r_count, n_count, k;
    logic              r_stop;
    logic [ftu_pkg::BURST_MAX-1:0][7:0] bytes;
    logic [ftu_pkg::BCNT_W-1:0]         cnt;
    logic [7:0]        b;

    always_comb begin
        b       = i_in_byte;
        m       = i_start_of_text ? ftu_pkg::M_START : r_mode;
        k       = i_start_of_text ? '0 : r_count;
        bytes   = {ftu_pkg::BURST_MAX{ftu_pkg::CH_DASH}};
        cnt     = '0;
        n_mode  = m;
        n_count = k;
        case (m)
            ftu_pkg::M_QUOTED: begin
                bytes[0] = b;
                cnt      = ftu_pkg::BCNT_W'(1);
                if (b == ftu_pkg::CH_NL) n_mode = ftu_pkg::M_START;
            end
            ftu_pkg::M_PLAIN: begin
                if (b == ftu_pkg::CH_SP) begin
                    n_mode = ftu_pkg::M_SP;
                end else begin
                    bytes[0] = b;
                    cnt      = ftu_pkg::BCNT_W'(1);
                    if (b == ftu_pkg::CH_NL) n_mode = ftu_pkg::M_START;
                end
            end
            ftu_pkg::M_SP: begin
                if (b == ftu_pkg::CH_NL) begin
                    n_mode = ftu_pkg::M_SPNL;
                end else if (b == ftu_pkg::CH_SP) begin
                    bytes[0] = ftu_pkg::CH_SP;
                    cnt      = ftu_pkg::BCNT_W'(1);
                end else begin
                    bytes[0] = ftu_pkg::CH_SP;
                    bytes[1] = b;
                    cnt      = ftu_pkg::BCNT_W'(2);
                    n_mode   = ftu_pkg::M_PLAIN;
                end
            end
            ftu_pkg::M_SPNL: begin
                if (b == ftu_pkg::CH_GT) begin
                    bytes[0] = ftu_pkg::CH_NL;
                    bytes[1] = ftu_pkg::CH_GT;
                    cnt      = ftu_pkg::BCNT_W'(2);
                    n_mode   = ftu_pkg::M_QUOTED;
                end else if (b == ftu_pkg::CH_NL) begin
                    bytes[0] = ftu_pkg::CH_NL;
                    bytes[1] = ftu_pkg::CH_NL;
                    cnt      = ftu_pkg::BCNT_W'(2);
                    n_mode   = ftu_pkg::M_START;
                end else if (b == ftu_pkg::CH_SP) begin
                    n_mode = ftu_pkg::M_SP;
                end else begin
                    bytes[0] = b;
                    cnt      = ftu_pkg::BCNT_W'(1);
                    n_mode   = ftu_pkg::M_PLAIN;
                end
            end
            ftu_pkg::M_CHECK: begin
                if (k >= 3'(ftu_pkg::SIG_LEN)) begin
                    n_mode = ftu_pkg::M_IGNORE;
                end else if (b == ftu_pkg::SIG_TEXT[k[ftu_pkg::SIG_W-1:0]]) begin
                    n_count = k + 3'd1;
                    if (k == 3'(ftu_pkg::SIG_LEN - 1)) n_mode = ftu_pkg::M_IGNORE;
                end else if (k == 3'(ftu_pkg::SIG_LEN - 1)) begin
                    // replay "-- " with the space held
                    bytes[2] = ftu_pkg::CH_SP;
                    bytes[3] = b;
                    if (b == ftu_pkg::CH_SP) begin
                        cnt    = ftu_pkg::BCNT_W'(3);
                        n_mode = ftu_pkg::M_SP;
                    end else begin
                        cnt    = ftu_pkg::BCNT_W'(4);
                        n_mode = ftu_pkg::M_PLAIN;
                    end
                end else begin
                    // replay k dashes, then b as plain text; a space b is held instead
                    bytes[k[ftu_pkg::BIDX_W-1:0]] = b;
                    if (b == ftu_pkg::CH_SP) begin
                        cnt    = ftu_pkg::BCNT_W'(k);
                        n_mode = ftu_pkg::M_SP;
                    end else begin
                        cnt    = ftu_pkg::BCNT_W'(k + 3'd1);
                        n_mode = (b == ftu_pkg::CH_NL) ? ftu_pkg::M_START : ftu_pkg::M_PLAIN;
                    end
                end
            end
            ftu_pkg::M_IGNORE: begin
                n_mode = ftu_pkg::M_IGNORE;
            end
            default: begin
                if (b == ftu_pkg::CH_GT) begin
                    bytes[0] = b;
                    cnt      = ftu_pkg::BCNT_W'(1);
                    n_mode   = ftu_pkg::M_QUOTED;
                end else if (b == ftu_pkg::CH_SP) begin
                    n_mode = ftu_pkg::M_PLAIN;
                end else if (r_stop && b == ftu_pkg::CH_DASH) begin
                    n_mode  = ftu_pkg::M_CHECK;
                    n_count = 3'd1;
                end else begin
                    if (r_stop) n_count = '0;
                    bytes[0] = b;
                    cnt      = ftu_pkg::BCNT_W'(1);
                    n_mode   = (b == ftu_pkg::CH_NL) ? ftu_pkg::M_START : ftu_pkg::M_PLAIN;
                end
            end
        endcase
    end

    assign o_valid          = (cnt != '0);
    assign o_burst.bytes    = bytes;
    assign o_burst.last_idx = ftu_pkg::BIDX_W'(cnt - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ftu_pkg::M_START;
            r_count <= '0;
            r_stop  <= 1'b1;
        end else begin
            if (i_cfg_we) r_stop <= i_cfg_wdata;
            if (i_accept) begin
                r_mode  <= n_mode;
                r_count <= n_count;
            end
        end
    end

endmodule

### hdl/ftu_queue.sv
// Short queue of byte bursts between front and back end.
module ftu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ftu_pkg::t_burst i_data,
    output logic            o_full,
    input  logic            i_pop,
    output ftu_pkg::t_burst o_data,
    output logic            o_empty
);

    ftu_pkg::t_burst r_mem [ftu_pkg::QDEPTH];
    logic [ftu_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [ftu_pkg::QCNT_W-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == ftu_pkg::QCNT_W'(ftu_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

### hdl/ftu_back.sv
// Back end: serialises bursts into single result items.
module ftu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  ftu_pkg::t_burst i_q_data,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);

    ftu_pkg::t_burst r_burst;
    logic [ftu_pkg::BIDX_W-1:0] r_idx;
    logic r_valid;
    logic last, take_out, done;

    assign last          = (r_idx == r_burst.last_idx);
    assign take_out      = i_pop && r_valid;
    assign done          = take_out && last;
    assign o_q_pop       = !i_q_empty && (!r_valid || done);
    assign o_empty       = !r_valid;
    assign o_out_byte    = r_burst.bytes[r_idx];
    assign o_last_of_run = last;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_burst <= i_q_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (o_q_pop) begin
                r_valid <= 1'b1;
                r_idx   <= '0;
            end else if (done) begin
                r_valid <= 1'b0;
            end else if (take_out) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

### hdl/flowed_text_unwrap_sig_strip.sv
// Top level of the flowed-text unwrapper with signature stop.
//
//   channel  direction  handshake    payload
//   input    in         push / full  i_in_byte, i_start_of_text
//   result   out        pop / empty  o_out_byte, o_last_of_run
//   config   in         i_cfg_we     i_cfg_wdata (stop_at_signature)
//
// One item is taken per cycle while the burst queue has room; each item gives
// zero to four result items, delivered one per cycle by the back end while pop is held.
// A result reaches the output through the burst queue and then the back end's burst register.
// The four-entry burst queue sets how long the input can run ahead of a
// stalled result side before full rises.
// Synchronous active-low reset; stop_at_signature resets to 1.
module flowed_text_unwrap_sig_strip (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_start_of_text,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    ftu_pkg::t_burst f_burst, q_data;
    logic f_valid, accept, q_full, q_empty, q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    ftu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_start_of_text(i_start_of_text),
        .o_valid        (f_valid),
        .o_burst        (f_burst)
    );

    ftu_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept && f_valid),
        .i_data (f_burst),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (q_data),
        .o_empty(q_empty)
    );

    ftu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_of_run) |=> !empty)
        else $error("result ran dry inside a burst");

    a_drain_to_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last_of_run && q_empty && !(accept && f_valid)) |=> empty)
        else $error("result shown with nothing queued");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("reset left items behind");

endmodule
